FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define STS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define STS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define STS_ASSERT(lbl, clk, rst, prop, msg)

`define STS_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sorted table search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;

  // Function codes of a request transaction
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic               func;
    logic               first;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;       // latch request, set up search bounds
    logic probe;        // read the midpoint entry
    logic update;       // narrow the search window from read data
    logic start_shift;  // arm the shift pointer at the entry count
    logic shift;        // move one entry up, write the pending one
    logic insert;       // write the new value at its slot
    logic check_read;   // read the candidate entry of a query
    logic check_hit;    // compare the candidate entry with the key
    logic clear_hit;    // mark the query as a miss
    logic set_ovf;      // record a dropped load
    logic load_result;  // fill the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_load;
    logic full;
    logic search_done;
    logic lo_in_table;
    logic shift_done;
  } status_t;

endpackage

`default_nettype wire

FILE: src/sorted_table_first_match_search.sv
// Query: accept, a binary search of up to ceil(log2(n+1)) probes over n entries, then
// the candidate read and compare, and the result hand-off to the output register.
// Load: the same probe loop for the slot, then one entry moved up per cycle through the
// table's read and write ports, then the insert; a load into a full table only sets the drop flag.
// One transaction is in work at a time; a finished result waits in an output register.
// Reset clears entry count, drop flag and control; table contents stay undefined.
// ----------------------------------------------------------------------------
// sorted_table_first_match_search
// Sorted value table with insertion load and leftmost-match binary search.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_first_match_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  output logic          req_stall,
  input  sts_pkg::req_t req,
  output logic          rsp_valid,
  input  wire           rsp_stall,
  output sts_pkg::rsp_t rsp
);
  import sts_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Table and search datapath
  sts_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

FILE: src/sts_dpath.sv
// ----------------------------------------------------------------------------
// sts_dpath
// Table memory, search window, shift pointer, entry counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sts_dpath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire              clk,
  input  wire              rst,
  input  sts_pkg::req_t    req,
  input  sts_pkg::cmd_t    cmd,
  output sts_pkg::status_t status,
  output sts_pkg::rsp_t    rsp
);
  import sts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data;

  logic               func_q;
  logic [VALUE_W-1:0] key;
  logic [CW-1:0]      count;
  logic               ovf;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      sh;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic               hit;
  rsp_t               rsp_q;

  logic [CW-1:0]      span;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      sh_dec;
  logic               sh_more;
  logic               go_right;
  logic [CW:0]        lo_inc;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // Search midpoint and shift pointer arithmetic
  assign span     = hi - lo;
  assign mid      = lo + (span >> 1);
  assign sh_dec   = sh - 1'b1;
  assign sh_more  = (sh > lo);
  assign lo_inc   = {1'b0, lo} + 1'b1;
  // Loads insert after equal copies, queries stop at the first copy
  assign go_right = (func_q == FUNC_LOAD) ? (rd_data <= key) : (rd_data < key);

  // Select memory port addresses
  always_comb begin
    rd_en   = cmd.probe | cmd.check_read | (cmd.shift & sh_more);
    rd_addr = sh_dec[AW-1:0];
    if (cmd.probe) begin
      rd_addr = mid[AW-1:0];
    end else if (cmd.check_read) begin
      rd_addr = lo[AW-1:0];
    end
    wr_en   = (cmd.shift & pend) | cmd.insert;
    wr_addr = cmd.insert ? lo[AW-1:0] : pend_addr;
    wr_data = cmd.insert ? key : rd_data;
  end

  // Table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  // Control state: entry count, drop flag, pending shift write
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      pend  <= 1'b0;
    end else begin
      if (cmd.accept && req.func == FUNC_LOAD && req.first) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.insert) begin
        count <= count + 1'b1;
      end
      if (cmd.start_shift) begin
        pend <= 1'b0;
      end else if (cmd.shift) begin
        pend <= sh_more;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= req.func;
      key    <= req.value;
      lo     <= '0;
      hi     <= (req.func == FUNC_LOAD && req.first) ? '0 : count;
    end
    if (cmd.update) begin
      if (go_right) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.start_shift) begin
      sh <= count;
    end
    if (cmd.shift && sh_more) begin
      sh        <= sh_dec;
      pend_addr <= sh[AW-1:0];
    end
    if (cmd.clear_hit) begin
      hit <= 1'b0;
    end
    if (cmd.check_hit) begin
      hit <= (rd_data == key);
    end
    if (cmd.load_result) begin
      rsp_q.found    <= hit;
      rsp_q.position <= hit ? POS_W'(lo_inc) : '0;
      rsp_q.overflow <= ovf;
    end
  end

  assign status.is_load     = (func_q == FUNC_LOAD);
  assign status.full        = (count == DEPTH_C);
  assign status.search_done = (lo >= hi);
  assign status.lo_in_table = (lo < count);
  assign status.shift_done  = !sh_more && !pend;
  assign rsp                = rsp_q;

  `STS_ASSERT(a_insert_room, clk, rst, cmd.insert |-> (count < DEPTH_C), "insert into full table")
  `STS_ASSERT(a_probe_window, clk, rst, cmd.probe |-> (lo < hi) && (hi <= count), "bad window")
  `STS_ASSERT(a_count_step, clk, rst, cmd.insert |=> (count == $past(count) + 1'b1), "count step")
  `STS_ASSERT_NEVER(a_wr_clash, clk, rst, cmd.insert && cmd.shift, "insert during shift")

endmodule

`default_nettype wire

FILE: src/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl
// Sequencer for search, shift-insert and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sts_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  wire              rsp_stall,
  output sts_pkg::cmd_t    cmd,
  input  sts_pkg::status_t status
);
  import sts_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_PROBE   = 7'b0000010,
    ST_COMPARE = 7'b0000100,
    ST_SHIFT   = 7'b0001000,
    ST_INSERT  = 7'b0010000,
    ST_CHECK   = 7'b0100000,
    ST_RESULT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status.is_load && status.full) begin
          cmd.set_ovf = 1'b1;
          state_next  = ST_IDLE;
        end else if (!status.search_done) begin
          cmd.probe  = 1'b1;
          state_next = ST_COMPARE;
        end else if (status.is_load) begin
          cmd.start_shift = 1'b1;
          state_next      = ST_SHIFT;
        end else if (status.lo_in_table) begin
          cmd.check_read = 1'b1;
          state_next     = ST_CHECK;
        end else begin
          cmd.clear_hit = 1'b1;
          state_next    = ST_RESULT;
        end
      end
      ST_COMPARE: begin
        cmd.update = 1'b1;
        state_next = ST_PROBE;
      end
      ST_SHIFT: begin
        if (status.shift_done) begin
          state_next = ST_INSERT;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CHECK: begin
        cmd.check_hit = 1'b1;
        state_next    = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state, hold output valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `STS_ASSERT(a_result_room, clk, rst, cmd.load_result |-> out_free, "result register busy")
  `STS_ASSERT(a_busy_after_accept, clk, rst, cmd.accept |=> req_stall, "accept while busy")
  `STS_ASSERT(a_ovf_on_full, clk, rst, cmd.set_ovf |-> status.is_load && status.full, "bad drop")

endmodule

`default_nettype wire
